/* rtl/lcd4_pkg.sv */
// Shared types, codes and helpers of the 4-bit character LCD controller.
package lcd4_pkg;

  localparam int unsigned WaitBitsDefault = 16;

  // Sequencer phases: power-up wait, wake-up nibbles and waits, 4-bit nibble, init bytes,
  // idle, request byte and the long wait after clear or home.
  typedef enum logic [4:0] {
    PH_PWR      = 5'd0,
    PH_NIB3_A   = 5'd1,
    PH_WAIT_A   = 5'd2,
    PH_NIB3_B   = 5'd3,
    PH_WAIT_B   = 5'd4,
    PH_NIB3_C   = 5'd5,
    PH_WAIT_C   = 5'd6,
    PH_NIB2     = 5'd7,
    PH_FSET     = 5'd8,
    PH_DCTL     = 5'd9,
    PH_EMODE    = 5'd10,
    PH_IDLE     = 5'd11,
    PH_REQ      = 5'd12,
    PH_LONG     = 5'd13
  } lcd4_phase_e;

  typedef enum logic [1:0] {
    STEP_SETUP  = 2'd0,
    STEP_HIGH   = 2'd1,
    STEP_SETTLE = 2'd2
  } lcd4_step_e;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_CLEAR  = 3'd1,
    CMD_HOME   = 3'd2,
    CMD_CURSOR = 3'd3,
    CMD_WRITE  = 3'd4,
    CMD_FLAG   = 3'd5
  } lcd4_cmd_e;

  typedef enum logic [1:0] {
    FLAG_DISPLAY = 2'd0,
    FLAG_CURSOR  = 2'd1,
    FLAG_BLINK   = 2'd2
  } lcd4_flag_e;

  typedef enum logic [2:0] {
    REG_FSET       = 3'd0,
    REG_DCTL       = 3'd1,
    REG_EMODE      = 3'd2,
    REG_PWR_WAIT   = 3'd3,
    REG_INIT_WAIT  = 3'd4,
    REG_SHORT_WAIT = 3'd5,
    REG_SETTLE     = 3'd6,
    REG_LONG_WAIT  = 3'd7
  } lcd4_reg_e;

  localparam logic [7:0]  FsetReset      = 8'h28;
  localparam logic [7:0]  DctlReset      = 8'h0F;
  localparam logic [7:0]  EmodeReset     = 8'h06;
  localparam logic [15:0] PwrWaitReset   = 16'd50000;
  localparam logic [15:0] InitWaitReset  = 16'd5000;
  localparam logic [15:0] ShortWaitReset = 16'd150;
  localparam logic [15:0] SettleReset    = 16'd50;
  localparam logic [15:0] LongWaitReset  = 16'd2000;

  localparam logic [7:0] InstrClear   = 8'h01;
  localparam logic [7:0] InstrHome    = 8'h02;
  localparam logic [1:0] InstrRow0    = 2'b10;  // 0x80 | col
  localparam logic [1:0] InstrRow1    = 2'b11;  // 0x80 | (0x40 + col)
  localparam logic [4:0] InstrDispCtl = 5'b00001;
  localparam logic [3:0] NibWake      = 4'h3;
  localparam logic [3:0] NibFourBit   = 4'h2;

  // Request fields, row in the lowest bits.
  typedef struct packed {
    logic       flag_value;
    logic [1:0] flag_select;
    logic [7:0] char_byte;
    logic [5:0] col;
    logic [1:0] row;
  } lcd4_req_t;

  // Result fields, pin_rs in the lowest bit.
  typedef struct packed {
    logic       accepted;
    logic       ready_res;
    logic [3:0] pin_data;
    logic       pin_en;
    logic       pin_rs;
  } lcd4_res_t;

  typedef struct packed {
    logic       we;
    lcd4_reg_e  addr;
    logic [15:0] data;
  } lcd4_cfg_t;

  function automatic logic is_wait(lcd4_phase_e p);
    return (p == PH_PWR) || (p == PH_WAIT_A) || (p == PH_WAIT_B) ||
           (p == PH_WAIT_C) || (p == PH_LONG);
  endfunction

  function automatic logic is_byte(lcd4_phase_e p);
    return (p == PH_FSET) || (p == PH_DCTL) || (p == PH_EMODE) || (p == PH_REQ);
  endfunction

  function automatic lcd4_phase_e next_phase(lcd4_phase_e p, logic long_after);
    lcd4_phase_e n;
    case (p)
      PH_PWR:    n = PH_NIB3_A;
      PH_NIB3_A: n = PH_WAIT_A;
      PH_WAIT_A: n = PH_NIB3_B;
      PH_NIB3_B: n = PH_WAIT_B;
      PH_WAIT_B: n = PH_NIB3_C;
      PH_NIB3_C: n = PH_WAIT_C;
      PH_WAIT_C: n = PH_NIB2;
      PH_NIB2:   n = PH_FSET;
      PH_FSET:   n = PH_DCTL;
      PH_DCTL:   n = PH_EMODE;
      PH_REQ:    n = long_after ? PH_LONG : PH_IDLE;
      default:   n = PH_IDLE;
    endcase
    return n;
  endfunction

endpackage

/* rtl/lcd4_seq.sv */
// Power-up and request sequencer with the configuration registers.
module lcd4_seq import lcd4_pkg::*; #(
  parameter int unsigned WAIT_BITS = WaitBitsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  input  lcd4_cmd_e cmd_i,
  input  lcd4_req_t req_i,
  input  lcd4_cfg_t cfg_i,
  output lcd4_res_t res_o
);

  localparam int unsigned CmpBits = (WAIT_BITS > 16) ? WAIT_BITS : 16;
  localparam logic [CmpBits-1:0] WaitMaxW = (CmpBits'(1) << WAIT_BITS) - CmpBits'(1);

  function automatic logic [WAIT_BITS-1:0] sat_lim(logic [15:0] v);
    logic [CmpBits-1:0] w;
    w = CmpBits'(v);
    if (w > WaitMaxW) w = WaitMaxW;
    return w[WAIT_BITS-1:0];
  endfunction

  function automatic logic [WAIT_BITS-1:0] lim_of(lcd4_phase_e p,
      logic [WAIT_BITS-1:0] pwr, logic [WAIT_BITS-1:0] init,
      logic [WAIT_BITS-1:0] shrt, logic [WAIT_BITS-1:0] lng);
    logic [WAIT_BITS-1:0] l;
    case (p)
      PH_PWR:               l = pwr;
      PH_WAIT_A, PH_WAIT_B: l = init;
      PH_WAIT_C:            l = shrt;
      PH_LONG:              l = lng;
      default:              l = '0;
    endcase
    return l;
  endfunction

  // configuration
  logic [7:0]  fset_q, dctl_q, emode_q;
  logic [15:0] pwr_wait_q, init_wait_q, short_wait_q, settle_q, long_wait_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fset_q       <= FsetReset;
      dctl_q       <= DctlReset;
      emode_q      <= EmodeReset;
      pwr_wait_q   <= PwrWaitReset;
      init_wait_q  <= InitWaitReset;
      short_wait_q <= ShortWaitReset;
      settle_q     <= SettleReset;
      long_wait_q  <= LongWaitReset;
    end else if (cfg_i.we) begin
      case (cfg_i.addr)
        REG_FSET:       fset_q       <= cfg_i.data[7:0];
        REG_DCTL:       dctl_q       <= cfg_i.data[7:0];
        REG_EMODE:      emode_q      <= cfg_i.data[7:0];
        REG_PWR_WAIT:   pwr_wait_q   <= cfg_i.data;
        REG_INIT_WAIT:  init_wait_q  <= cfg_i.data;
        REG_SHORT_WAIT: short_wait_q <= cfg_i.data;
        REG_SETTLE:     settle_q     <= cfg_i.data;
        REG_LONG_WAIT:  long_wait_q  <= cfg_i.data;
        default:        ;
      endcase
    end
  end

  logic [WAIT_BITS-1:0] lim_pwr, lim_init, lim_short, lim_long, lim_settle;

  always_comb begin
    lim_pwr    = sat_lim(pwr_wait_q);
    lim_init   = sat_lim(init_wait_q);
    lim_short  = sat_lim(short_wait_q);
    lim_long   = sat_lim(long_wait_q);
    lim_settle = sat_lim(settle_q);
    // a zero settle time still lets enable fall for one tick
    if (lim_settle == '0) lim_settle = WAIT_BITS'(1);
  end

  // sequencer state
  lcd4_phase_e          phase_q, phase_d;
  lcd4_step_e           step_q, step_d;
  logic [WAIT_BITS-1:0] wc_q, wc_d;
  logic [7:0]           pb_q, pb_d;
  logic                 prs_q, prs_d;
  logic                 low_q, low_d;
  logic                 long_q, long_d;
  logic [2:0]           flags_q, flags_d;
  logic                 rs_q, rs_d;
  logic                 en_q, en_d;
  logic [3:0]           data_q, data_d;

  logic                 acc;
  logic                 do_enter;
  lcd4_phase_e          enter_p, enter_eff;
  logic [WAIT_BITS-1:0] wc_inc;
  logic [2:0]           flag_bit, flags_new;

  always_comb begin
    phase_d   = phase_q;
    step_d    = step_q;
    wc_d      = wc_q;
    pb_d      = pb_q;
    prs_d     = prs_q;
    low_d     = low_q;
    long_d    = long_q;
    flags_d   = flags_q;
    rs_d      = rs_q;
    en_d      = en_q;
    data_d    = data_q;
    acc       = 1'b0;
    do_enter  = 1'b0;
    enter_p   = PH_IDLE;
    enter_eff = PH_IDLE;
    flag_bit  = 3'b100 >> req_i.flag_select;
    flags_new = req_i.flag_value ? (flags_q | flag_bit) : (flags_q & ~flag_bit);
    wc_inc    = (&wc_q) ? wc_q : wc_q + WAIT_BITS'(1);

    if (req_valid_i) begin
      if (cmd_i == CMD_TICK) begin
        if (is_wait(phase_q)) begin
          if (wc_inc >= lim_of(phase_q, lim_pwr, lim_init, lim_short, lim_long)) begin
            do_enter = 1'b1;
            enter_p  = next_phase(phase_q, long_q);
          end else begin
            wc_d = wc_inc;
          end
        end else if (phase_q != PH_IDLE) begin
          case (step_q)
            STEP_SETUP: begin
              if (is_byte(phase_q)) begin
                data_d = low_q ? pb_q[3:0] : pb_q[7:4];
                rs_d   = prs_q;
              end else begin
                data_d = (phase_q == PH_NIB2) ? NibFourBit : NibWake;
                rs_d   = 1'b0;
              end
              en_d   = 1'b0;
              step_d = STEP_HIGH;
            end
            STEP_HIGH: begin
              en_d   = 1'b1;
              step_d = STEP_SETTLE;
              wc_d   = '0;
            end
            default: begin
              en_d = 1'b0;
              wc_d = wc_inc;
              if (wc_inc >= lim_settle) begin
                if (is_byte(phase_q) && !low_q) begin
                  low_d  = 1'b1;
                  step_d = STEP_SETUP;
                  wc_d   = '0;
                end else begin
                  do_enter = 1'b1;
                  enter_p  = next_phase(phase_q, long_q);
                end
              end
            end
          endcase
        end
      end else if (phase_q == PH_IDLE) begin
        case (cmd_i)
          CMD_CLEAR: begin
            acc = 1'b1; pb_d = InstrClear; prs_d = 1'b0; long_d = 1'b1;
            do_enter = 1'b1; enter_p = PH_REQ;
          end
          CMD_HOME: begin
            acc = 1'b1; pb_d = InstrHome; prs_d = 1'b0; long_d = 1'b1;
            do_enter = 1'b1; enter_p = PH_REQ;
          end
          CMD_CURSOR: begin
            acc = 1'b1;
            if (req_i.row == 2'd0 || req_i.row == 2'd1) begin
              pb_d     = {(req_i.row == 2'd0) ? InstrRow0 : InstrRow1, req_i.col};
              prs_d    = 1'b0;
              long_d   = 1'b0;
              do_enter = 1'b1;
              enter_p  = PH_REQ;
            end
          end
          CMD_WRITE: begin
            acc = 1'b1; pb_d = req_i.char_byte; prs_d = 1'b1; long_d = 1'b0;
            do_enter = 1'b1; enter_p = PH_REQ;
          end
          CMD_FLAG: begin
            acc = 1'b1;
            if (req_i.flag_select != 2'd3) begin
              flags_d  = flags_new;
              pb_d     = {InstrDispCtl, flags_new};
              prs_d    = 1'b0;
              long_d   = 1'b0;
              do_enter = 1'b1;
              enter_p  = PH_REQ;
            end
          end
          default: ;
        endcase
      end
    end

    // entering a phase; a zero-length wait falls straight through
    if (do_enter) begin
      if (is_wait(enter_p) &&
          lim_of(enter_p, lim_pwr, lim_init, lim_short, lim_long) == '0) begin
        enter_eff = next_phase(enter_p, long_d);
      end else begin
        enter_eff = enter_p;
      end
      phase_d = enter_eff;
      wc_d    = '0;
      step_d  = STEP_SETUP;
      low_d   = 1'b0;
      case (enter_eff)
        PH_FSET:  begin pb_d = fset_q;  prs_d = 1'b0; end
        PH_DCTL:  begin pb_d = dctl_q;  prs_d = 1'b0; end
        PH_EMODE: begin pb_d = emode_q; prs_d = 1'b0; end
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PWR;
      step_q  <= STEP_SETUP;
      wc_q    <= '0;
      pb_q    <= '0;
      prs_q   <= 1'b0;
      low_q   <= 1'b0;
      long_q  <= 1'b0;
      flags_q <= 3'b111;
      rs_q    <= 1'b0;
      en_q    <= 1'b0;
      data_q  <= '0;
    end else if (req_valid_i) begin
      phase_q <= phase_d;
      step_q  <= step_d;
      wc_q    <= wc_d;
      pb_q    <= pb_d;
      prs_q   <= prs_d;
      low_q   <= low_d;
      long_q  <= long_d;
      flags_q <= flags_d;
      rs_q    <= rs_d;
      en_q    <= en_d;
      data_q  <= data_d;
    end
  end

  always_comb begin
    res_o.pin_rs    = rs_d;
    res_o.pin_en    = en_d;
    res_o.pin_data  = data_d;
    res_o.ready_res = (phase_d == PH_IDLE);
    res_o.accepted  = acc;
  end

endmodule

/* rtl/char_lcd_4bit_interface_core.sv */
// Top level of the 4-bit character LCD controller: stream ports and result buffering.
//
// Usage: every input item on the s_axis channel is either a one-microsecond
// tick (tuser = 0) or a request (clear, home, set cursor, write character,
// set display flag). Each accepted item yields exactly one result item on
// m_axis: the RS, EN and D7..D4 levels after the item, an idle flag and
// whether the request was taken. Requests made while busy are refused.
// Each result is registered before it appears on m_axis.
// Throughput: one item per cycle while s_axis_tready_o is high; the sequencer update is a single
// registered step.
// Reset: the sequencer restarts the power-up sequence (long wait, three
// wake-up nibbles, 4-bit nibble, three init bytes) and all configuration
// registers return to their defaults. The cfg channel is always ready.
// Stall: an output register plus one skid entry hold results while m_axis
// is not ready; s_axis_tready_o drops only once both are full.
module char_lcd_4bit_interface_core import lcd4_pkg::*; #(
  parameter int unsigned WAIT_BITS = WaitBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [1:0] row, [7:2] col, [15:8] char_byte, [17:16] flag_select,
  // [18] flag_value, [23:19] zero
  input  logic [23:0] s_axis_tdata_i,
  // [2:0] cmd
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] pin_rs, [1] pin_en, [5:2] pin_data, [6] ready_res, [7] accepted
  output logic [7:0]  m_axis_tdata_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_addr_i,
  input  logic [15:0] cfg_data_i
);

  logic      in_fire;
  lcd4_cfg_t cfg;
  lcd4_res_t res;
  lcd4_res_t out_q, skid_q;
  logic      out_valid_q, skid_valid_q;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !skid_valid_q;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    cfg.we   = cfg_valid_i;
    cfg.addr = lcd4_reg_e'(cfg_addr_i);
    cfg.data = cfg_data_i;
  end

  lcd4_seq #(
    .WAIT_BITS (WAIT_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_fire),
    .cmd_i       (lcd4_cmd_e'(s_axis_tuser_i)),
    .req_i       (lcd4_req_t'(s_axis_tdata_i[18:0])),
    .cfg_i       (cfg),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (in_fire) begin
      if (!out_valid_q || m_axis_tready_i) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_valid_q && m_axis_tready_i) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (!out_valid_q || m_axis_tready_i) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end else if (out_valid_q && m_axis_tready_i && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

endmodule

/* rtl/lcd4_chk.sv */
// Port-level checks of the LCD controller and their bind to the top level.
module lcd4_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o
);

  // a refused input (both result slots occupied) must leave a result pending on m_axis
  a_stall_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with no result pending");

  // every taken item leaves a result valid on m_axis on the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> m_axis_tvalid_o)
    else $error("accepted item produced no result");

  // enable only pulses while a nibble is being sent, never when idle
  a_en_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[1] |-> !m_axis_tdata_o[6])
    else $error("enable high while idle");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

endmodule

bind char_lcd_4bit_interface_core lcd4_chk u_lcd4_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
